// File: hw/rtl/pse_pkg.sv
// ============================================================================
// pse_pkg: shared types and constants of the postfix stack evaluator
// Token codes, internal operation codes, status codes and divider interface.
// ============================================================================
package pse_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic [2:0] status_t;
    typedef logic [2:0] op_t;

    // Operator tokens as they arrive on the token input.
    localparam logic signed [WORD_W-1:0] TOK_ADD = -32'sd1;
    localparam logic signed [WORD_W-1:0] TOK_SUB = -32'sd2;
    localparam logic signed [WORD_W-1:0] TOK_MUL = -32'sd3;
    localparam logic signed [WORD_W-1:0] TOK_DIV = -32'sd4;
    localparam logic signed [WORD_W-1:0] TOK_END = 32'sd0;

    localparam op_t OP_ADD  = 3'd0;
    localparam op_t OP_SUB  = 3'd1;
    localparam op_t OP_MUL  = 3'd2;
    localparam op_t OP_DIV  = 3'd3;
    localparam op_t OP_DROP = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_UNDERFLOW = 3'd1;
    localparam status_t ST_LEFTOVER  = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_DIVZERO   = 3'd4;
    localparam status_t ST_OVERFLOW  = 3'd5;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: hw/rtl/pse_stack_ram.sv
// ============================================================================
// pse_stack_ram: operand stack storage
// Single-port-write, single-port-read synchronous RAM with registered read.
// ============================================================================
module pse_stack_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [pse_pkg::WORD_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [pse_pkg::WORD_W-1:0]   rd_data
);

    logic [pse_pkg::WORD_W-1:0] mem [DEPTH];
    logic [pse_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/pse_divider.sv
// ============================================================================
// pse_divider: signed truncating divider
// Restoring radix-2 division on magnitudes, one quotient bit per cycle.
// ============================================================================
module pse_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pse_pkg::div_req_t req,
    output pse_pkg::div_rsp_t rsp
);

    localparam int unsigned W  = pse_pkg::WORD_W;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic          neg_reg, neg_next;

    logic [W:0]    trial;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;

    assign mag_a = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
    assign mag_b = req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = mag_a;
            mb_next   = mag_b;
            neg_next  = req.dividend[W-1] ^ req.divisor[W-1];
        end
        else if (busy_reg)
        begin
            // The dividend shifts out of the top of quo while quotient bits enter below.
            if (trial >= {1'b0, mb_reg})
            begin
                rem_next = trial - {1'b0, mb_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// File: hw/rtl/postfix_stack_evaluator_top.sv
// ============================================================================
// postfix_stack_evaluator_top: postfix expression evaluator
// Evaluates a stream of postfix tokens on an operand stack held in RAM.
// ============================================================================
//
//  Channel   Signals                              Direction  Moves
//  token     token_valid, token_stall, token      in         one token per item
//  result    result_valid, result_stall,          out        one item per end token
//            value, status
//
//  A push, an end token, an ignored token or one that latches an error is
//  handled in the idle state, as is a drop that empties the stack. Add,
//  subtract, multiply and any other drop read the stack RAM below the cached
//  top, then combine in the execute state. Divide reads the RAM, starts the
//  bit-serial divider (32 steps) and waits in the divide state for its result.
//  Reset clears the depth, the error code and the result valid flag; the RAM
//  needs no clearing because only entries below the depth are read.
//  A waiting result stalls only a following end token; other tokens go on.
//
module postfix_stack_evaluator_top #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                token_valid,
    output logic                                token_stall,
    input  logic signed [pse_pkg::WORD_W-1:0]   token,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pse_pkg::WORD_W-1:0]   value,
    output logic [2:0]                          status
);

    localparam int unsigned W  = pse_pkg::WORD_W;
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [DW-1:0]          depth_reg, depth_next;
    pse_pkg::status_t       err_reg, err_next;
    pse_pkg::op_t           op_reg, op_next;
    logic [W-1:0]           top_reg, top_next;

    logic                   res_valid_reg, res_valid_next;
    logic [W-1:0]           res_value_reg, res_value_next;
    pse_pkg::status_t       res_status_reg, res_status_next;

    logic                   accept;
    logic                   is_end;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [W-1:0]           ram_rd_data;
    logic [W-1:0]           product;
    pse_pkg::div_req_t      div_req;
    pse_pkg::div_rsp_t      div_rsp;
    pse_pkg::op_t           tok_op;

    assign is_end      = (token == pse_pkg::TOK_END);
    assign token_stall = (state_reg != S_IDLE) || (res_valid_reg && result_stall && is_end);
    assign accept      = token_valid && !token_stall;
    assign product     = ram_rd_data * top_reg;

    always_comb
    begin
        case (token)
            pse_pkg::TOK_ADD: tok_op = pse_pkg::OP_ADD;
            pse_pkg::TOK_SUB: tok_op = pse_pkg::OP_SUB;
            pse_pkg::TOK_MUL: tok_op = pse_pkg::OP_MUL;
            pse_pkg::TOK_DIV: tok_op = pse_pkg::OP_DIV;
            default:          tok_op = pse_pkg::OP_DROP;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        depth_next       = depth_reg;
        err_next         = err_reg;
        op_next          = op_reg;
        top_next         = top_reg;
        res_valid_next   = res_valid_reg && result_stall;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = AW'(depth_reg - DW'(1));
        ram_rd_en        = 1'b0;
        ram_rd_addr      = AW'(depth_reg - DW'(2));
        div_req.start    = 1'b0;
        div_req.dividend = ram_rd_data;
        div_req.divisor  = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_end)
                    begin
                        res_valid_next = 1'b1;
                        res_value_next = '0;
                        if (err_reg != pse_pkg::ST_OK)
                        begin
                            res_status_next = err_reg;
                        end
                        else if (depth_reg == '0)
                        begin
                            res_status_next = pse_pkg::ST_EMPTY;
                        end
                        else if (depth_reg > DW'(1))
                        begin
                            res_status_next = pse_pkg::ST_LEFTOVER;
                        end
                        else
                        begin
                            res_status_next = pse_pkg::ST_OK;
                            res_value_next  = top_reg;
                        end
                        depth_next = '0;
                        err_next   = pse_pkg::ST_OK;
                    end
                    else if (err_reg != pse_pkg::ST_OK)
                    begin
                        // Tokens are dropped until the end token once an error is held.
                    end
                    else if (!token[W-1])
                    begin
                        if (depth_reg >= DW'(STACK_DEPTH))
                        begin
                            err_next = pse_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            // The old top moves down into the RAM; the new value is cached.
                            ram_wr_en  = (depth_reg != '0);
                            top_next   = token;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    else if (depth_reg < DW'(2))
                    begin
                        err_next = pse_pkg::ST_UNDERFLOW;
                    end
                    else if ((tok_op == pse_pkg::OP_DIV) && (top_reg == '0))
                    begin
                        err_next = pse_pkg::ST_DIVZERO;
                    end
                    else if ((tok_op == pse_pkg::OP_DROP) && (depth_reg == DW'(2)))
                    begin
                        depth_next = '0;
                    end
                    else
                    begin
                        // A drop needs the entry under both operands as its new top.
                        ram_rd_en = 1'b1;
                        if (tok_op == pse_pkg::OP_DROP)
                        begin
                            ram_rd_addr = AW'(depth_reg - DW'(3));
                        end
                        op_next    = tok_op;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                depth_next = depth_reg - DW'(1);
                case (op_reg)
                    pse_pkg::OP_ADD: top_next = ram_rd_data + top_reg;
                    pse_pkg::OP_SUB: top_next = ram_rd_data - top_reg;
                    pse_pkg::OP_MUL: top_next = product;
                    pse_pkg::OP_DIV:
                    begin
                        div_req.start = 1'b1;
                        depth_next    = depth_reg;
                        state_next    = S_DIV;
                    end
                    default:
                    begin
                        top_next   = ram_rd_data;
                        depth_next = depth_reg - DW'(2);
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    top_next   = div_rsp.quotient;
                    depth_next = depth_reg - DW'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= pse_pkg::ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        top_reg        <= top_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    pse_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (top_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pse_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result_valid = res_valid_reg;
    assign value        = res_value_reg;
    assign status       = res_status_reg;

endmodule
